FILE: hw/rtl/kpt_pkg.sv
package kpt_pkg;

    localparam int RAW_W         = 8;
    localparam int KIND_W        = 4;
    localparam int CHAR_W        = 7;
    localparam int CODE_W        = 6;
    localparam int MASK_W        = 5;
    localparam int KPT_QUEUE_DEPTH = 2;

    localparam logic [6:0] CODE_LIMIT = 7'd57;

    localparam logic [CODE_W-1:0] KEY_CTRL  = 6'd29;
    localparam logic [CODE_W-1:0] KEY_FN    = 6'd41;
    localparam logic [CODE_W-1:0] KEY_SHIFT = 6'd42;
    localparam logic [CODE_W-1:0] KEY_ALT   = 6'd54;
    localparam logic [CODE_W-1:0] KEY_OPT   = 6'd55;
    localparam logic [CODE_W-1:0] KEY_UP    = 6'd23;
    localparam logic [CODE_W-1:0] KEY_DOWN  = 6'd37;
    localparam logic [CODE_W-1:0] KEY_B     = 6'd47;
    localparam logic [CODE_W-1:0] KEY_W     = 6'd17;
    localparam logic [CODE_W-1:0] KEY_M     = 6'd49;
    localparam logic [CODE_W-1:0] KEY_S     = 6'd31;

    // modifier mask bit positions
    localparam int M_CTRL  = 0;
    localparam int M_FN    = 1;
    localparam int M_SHIFT = 2;
    localparam int M_ALT   = 3;
    localparam int M_OPT   = 4;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 7'h08;
    localparam logic [CHAR_W-1:0] CH_ENTER     = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_FIRST     = 7'h20;
    localparam logic [CHAR_W-1:0] CH_LAST      = 7'h7E;
    localparam logic [CHAR_W-1:0] CH_U         = 7'h75;
    localparam logic [CHAR_W-1:0] CH_L         = 7'h6C;
    localparam logic [CHAR_W-1:0] CH_C         = 7'h63;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR      = 4'd0,
        KIND_ENTER     = 4'd1,
        KIND_BACKSPACE = 4'd2,
        KIND_FN_UP     = 4'd3,
        KIND_FN_DOWN   = 4'd4,
        KIND_FN_B      = 4'd5,
        KIND_FN_W      = 4'd6,
        KIND_FN_M      = 4'd7,
        KIND_FN_S      = 4'd8,
        KIND_CTRL_U    = 4'd9,
        KIND_CTRL_L    = 4'd10,
        KIND_CTRL_C    = 4'd11
    } kind_t;

    // press of a non-modifier key, with the Fn, Ctrl and Shift state held at that point
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              fn;
        logic              ctrl;
        logic              shift;
    } kpt_cmd_t;

    function automatic logic [CHAR_W-1:0] rom_base(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            6'd1:  ch = 7'h60;
            6'd2:  ch = 7'h31;
            6'd3:  ch = 7'h32;
            6'd4:  ch = 7'h33;
            6'd5:  ch = 7'h34;
            6'd6:  ch = 7'h35;
            6'd7:  ch = 7'h36;
            6'd8:  ch = 7'h37;
            6'd9:  ch = 7'h38;
            6'd10: ch = 7'h39;
            6'd11: ch = 7'h30;
            6'd12: ch = 7'h2D;
            6'd13: ch = 7'h3D;
            6'd14: ch = CH_BACKSPACE;
            6'd15: ch = 7'h09;
            6'd16: ch = 7'h71;
            6'd17: ch = 7'h77;
            6'd18: ch = 7'h65;
            6'd19: ch = 7'h72;
            6'd20: ch = 7'h74;
            6'd21: ch = 7'h79;
            6'd22: ch = 7'h75;
            6'd23: ch = 7'h69;
            6'd24: ch = 7'h6F;
            6'd25: ch = 7'h70;
            6'd26: ch = 7'h5B;
            6'd27: ch = 7'h5D;
            6'd28: ch = CH_ENTER;
            6'd30: ch = 7'h61;
            6'd31: ch = 7'h73;
            6'd32: ch = 7'h64;
            6'd33: ch = 7'h66;
            6'd34: ch = 7'h67;
            6'd35: ch = 7'h68;
            6'd36: ch = 7'h6A;
            6'd37: ch = 7'h6B;
            6'd38: ch = 7'h6C;
            6'd39: ch = 7'h3B;
            6'd40: ch = 7'h27;
            6'd43: ch = 7'h7A;
            6'd44: ch = 7'h78;
            6'd45: ch = 7'h63;
            6'd46: ch = 7'h76;
            6'd47: ch = 7'h62;
            6'd48: ch = 7'h6E;
            6'd49: ch = 7'h6D;
            6'd50: ch = 7'h2C;
            6'd51: ch = 7'h2E;
            6'd52: ch = 7'h2F;
            6'd53: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] rom_shift(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            6'd1:  ch = 7'h7E;
            6'd2:  ch = 7'h21;
            6'd3:  ch = 7'h40;
            6'd4:  ch = 7'h23;
            6'd5:  ch = 7'h24;
            6'd6:  ch = 7'h25;
            6'd7:  ch = 7'h5E;
            6'd8:  ch = 7'h26;
            6'd9:  ch = 7'h2A;
            6'd10: ch = 7'h28;
            6'd11: ch = 7'h29;
            6'd12: ch = 7'h5F;
            6'd13: ch = 7'h2B;
            6'd14: ch = CH_BACKSPACE;
            6'd15: ch = 7'h09;
            6'd16: ch = 7'h51;
            6'd17: ch = 7'h57;
            6'd18: ch = 7'h45;
            6'd19: ch = 7'h52;
            6'd20: ch = 7'h54;
            6'd21: ch = 7'h59;
            6'd22: ch = 7'h55;
            6'd23: ch = 7'h49;
            6'd24: ch = 7'h4F;
            6'd25: ch = 7'h50;
            6'd26: ch = 7'h7B;
            6'd27: ch = 7'h7D;
            6'd28: ch = CH_ENTER;
            6'd30: ch = 7'h41;
            6'd31: ch = 7'h53;
            6'd32: ch = 7'h44;
            6'd33: ch = 7'h46;
            6'd34: ch = 7'h47;
            6'd35: ch = 7'h48;
            6'd36: ch = 7'h4A;
            6'd37: ch = 7'h4B;
            6'd38: ch = 7'h4C;
            6'd39: ch = 7'h3A;
            6'd40: ch = 7'h22;
            6'd43: ch = 7'h5A;
            6'd44: ch = 7'h58;
            6'd45: ch = 7'h43;
            6'd46: ch = 7'h56;
            6'd47: ch = 7'h42;
            6'd48: ch = 7'h4E;
            6'd49: ch = 7'h4D;
            6'd50: ch = 7'h3C;
            6'd51: ch = 7'h3E;
            6'd52: ch = 7'h3F;
            6'd53: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: hw/rtl/kpt_raw_if.sv
interface kpt_raw_if
    import kpt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_event;

    modport source (output valid, output raw_event, input ready);
    modport sink   (input valid, input raw_event, output ready);
endinterface

FILE: hw/rtl/kpt_event_if.sv
interface kpt_event_if
    import kpt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output event_kind, output char_code, input ready);
    modport sink   (input valid, input event_kind, input char_code, output ready);
endinterface

FILE: hw/rtl/kpt_front.sv
module kpt_front
    import kpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    kpt_raw_if.sink          raw,
    input  logic             q_full,
    output logic             q_push,
    output kpt_cmd_t         q_cmd
);

    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic [MASK_W-1:0] mod_bit;
    logic [6:0]        code7;
    logic              pressed;
    logic              code_ok;
    logic              accept;

    assign raw.ready = !q_full;
    assign accept    = raw.valid && raw.ready;
    assign code7     = raw.raw_event[6:0];
    assign pressed   = raw.raw_event[7];
    assign code_ok   = (code7 != 7'd0) && (code7 < CODE_LIMIT);

    always_comb
    begin
        mod_bit = '0;
        unique case (code7[CODE_W-1:0])
            KEY_CTRL:  mod_bit[M_CTRL]  = 1'b1;
            KEY_FN:    mod_bit[M_FN]    = 1'b1;
            KEY_SHIFT: mod_bit[M_SHIFT] = 1'b1;
            KEY_ALT:   mod_bit[M_ALT]   = 1'b1;
            KEY_OPT:   mod_bit[M_OPT]   = 1'b1;
            default:   mod_bit = '0;
        endcase
        if (!code_ok)
        begin
            mod_bit = '0;
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (accept && (mod_bit != '0))
        begin
            mask_next = pressed ? (mask_reg | mod_bit) : (mask_reg & ~mod_bit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    // only presses of ordinary keys go on to the translator
    assign q_push      = accept && code_ok && pressed && (mod_bit == '0);
    assign q_cmd.code  = code7[CODE_W-1:0];
    assign q_cmd.fn    = mask_reg[M_FN];
    assign q_cmd.ctrl  = mask_reg[M_CTRL];
    assign q_cmd.shift = mask_reg[M_SHIFT];

endmodule

FILE: hw/rtl/kpt_queue.sv
module kpt_queue
    import kpt_pkg::*;
#(
    parameter int DEPTH = KPT_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  kpt_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     avail,
    output kpt_cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    kpt_cmd_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign avail   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && avail;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

FILE: hw/rtl/kpt_back.sv
module kpt_back
    import kpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_avail,
    input  kpt_cmd_t   q_cmd,
    output logic       q_pop,
    kpt_event_if.source evt
);

    logic              out_valid_reg;
    logic              out_valid_next;
    kind_t             kind_reg;
    logic [CHAR_W-1:0] char_reg;

    logic              emit;
    kind_t             kind;
    logic [CHAR_W-1:0] ch_out;
    logic [CHAR_W-1:0] ch_base;
    logic [CHAR_W-1:0] ch_sel;

    assign ch_base = rom_base(q_cmd.code);
    assign ch_sel  = q_cmd.shift ? rom_shift(q_cmd.code) : ch_base;

    always_comb
    begin
        emit   = 1'b0;
        kind   = KIND_CHAR;
        ch_out = '0;
        if (q_cmd.fn)
        begin
            emit = 1'b1;
            unique case (q_cmd.code)
                KEY_UP:   kind = KIND_FN_UP;
                KEY_DOWN: kind = KIND_FN_DOWN;
                KEY_B:    kind = KIND_FN_B;
                KEY_W:    kind = KIND_FN_W;
                KEY_M:    kind = KIND_FN_M;
                KEY_S:    kind = KIND_FN_S;
                default:  emit = 1'b0;
            endcase
        end
        else if (q_cmd.ctrl)
        begin
            emit = 1'b1;
            unique case (ch_base)
                CH_U:    kind = KIND_CTRL_U;
                CH_L:    kind = KIND_CTRL_L;
                CH_C:    kind = KIND_CTRL_C;
                default: emit = 1'b0;
            endcase
        end
        else if (ch_sel == CH_ENTER)
        begin
            emit = 1'b1;
            kind = KIND_ENTER;
        end
        else if (ch_sel == CH_BACKSPACE)
        begin
            emit = 1'b1;
            kind = KIND_BACKSPACE;
        end
        else if ((ch_sel >= CH_FIRST) && (ch_sel <= CH_LAST))
        begin
            emit   = 1'b1;
            ch_out = ch_sel;
        end
    end

    // a dropped key is consumed without touching the output register
    assign q_pop = q_avail && (!out_valid_reg || evt.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = emit;
        end
        else if (evt.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            kind_reg <= kind;
            char_reg <= ch_out;
        end
    end

    assign evt.valid      = out_valid_reg;
    assign evt.event_kind = kind_reg;
    assign evt.char_code  = char_reg;

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg != KIND_CHAR)) |-> (char_reg == '0))
        else $error("char code set on a non-character event");

    a_char_printable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_CHAR)) |->
        ((char_reg >= CH_FIRST) && (char_reg <= CH_LAST)))
        else $error("character event outside printable range");

endmodule

FILE: hw/rtl/keypad_event_translator.sv
// A result passes through the queue and then the output register after the transfer of the key event that causes it.
// Throughput: one key event per cycle; the front takes events while the queue has room.
// Modifier, release and unmapped events are absorbed and give no result.
// Reset (rst_n low, asynchronous): modifier mask cleared, queue emptied, output invalid.
module keypad_event_translator
    import kpt_pkg::*;
#(
    parameter int QUEUE_DEPTH = KPT_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    kpt_raw_if.sink     raw_ch,
    kpt_event_if.source event_ch
);

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_avail;
    kpt_cmd_t push_cmd;
    kpt_cmd_t pop_cmd;

    kpt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .raw    (raw_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (push_cmd)
    );

    kpt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .pop_cmd  (pop_cmd)
    );

    kpt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_avail (q_avail),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .evt     (event_ch)
    );

endmodule

FILE: tb/keypad_event_translator_tb.sv
`timescale 1ns / 1ps

module keypad_event_translator_tb;
    import kpt_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_KEYS = 900;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
    } exp_event_t;

    logic clk;
    logic rst_n;

    kpt_raw_if   raw_ch ();
    kpt_event_if event_ch ();

    keypad_event_translator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .raw_ch   (raw_ch),
        .event_ch (event_ch)
    );

    logic [MASK_W-1:0] held_mods;
    exp_event_t        pending_events [$];
    exp_event_t        front;
    int                err_count;
    int                keys_sent;
    int                keys_handled;
    int                events_checked;
    int                idle_cycles;
    int                rx_hold_len;
    bit                rx_quiet;
    bit                tx_quiet;

    always #2 clk = ~clk;

    // printable layout, one string per physical row
    function automatic logic [CHAR_W-1:0] keymap_char(input logic [CODE_W-1:0] code,
                                                      input logic shifted);
        string row;
        int    col;
        byte   b;
        row = "";
        col = 0;
        if (code == 14)
            return CH_BACKSPACE;
        if (code == 28)
            return CH_ENTER;
        if (code >= 1 && code <= 13)
        begin
            row = shifted ? "~!@#$%^&*()_+" : "`1234567890-=";
            col = code - 1;
        end
        else if (code >= 16 && code <= 27)
        begin
            row = shifted ? "QWERTYUIOP{}" : "qwertyuiop[]";
            col = code - 16;
        end
        else if (code >= 30 && code <= 40)
        begin
            row = shifted ? "ASDFGHJKL:\"" : "asdfghjkl;'";
            col = code - 30;
        end
        else if (code >= 43 && code <= 53)
        begin
            row = shifted ? "ZXCVBNM<>? " : "zxcvbnm,./ ";
            col = code - 43;
        end
        if (row.len() == 0)
            return '0;
        b = row[col];
        return b[CHAR_W-1:0];
    endfunction

    function automatic void predict_event(input logic [RAW_W-1:0] raw);
        logic [CODE_W-1:0] code;
        logic [CHAR_W-1:0] ch;
        logic              press;
        int                mod_bit;
        exp_event_t        ev;
        press = raw[RAW_W-1];
        if (raw[6:0] == '0 || raw[6:0] >= CODE_LIMIT)
            return;
        keys_handled++;
        code    = raw[CODE_W-1:0];
        ev.kind = KIND_CHAR;
        ev.ch   = '0;
        mod_bit = -1;
        case (code)
            KEY_CTRL:  mod_bit = M_CTRL;
            KEY_FN:    mod_bit = M_FN;
            KEY_SHIFT: mod_bit = M_SHIFT;
            KEY_ALT:   mod_bit = M_ALT;
            KEY_OPT:   mod_bit = M_OPT;
            default:   mod_bit = -1;
        endcase
        if (mod_bit >= 0)
        begin
            held_mods[mod_bit] = press;
            return;
        end
        if (!press)
            return;
        if (held_mods[M_FN])
        begin
            case (code)
                KEY_UP:   ev.kind = KIND_FN_UP;
                KEY_DOWN: ev.kind = KIND_FN_DOWN;
                KEY_B:    ev.kind = KIND_FN_B;
                KEY_W:    ev.kind = KIND_FN_W;
                KEY_M:    ev.kind = KIND_FN_M;
                KEY_S:    ev.kind = KIND_FN_S;
                default:  return;
            endcase
        end
        else if (held_mods[M_CTRL])
        begin
            // control chords look at the unshifted layer only
            ch = keymap_char(code, 1'b0);
            if (ch == CH_U)
                ev.kind = KIND_CTRL_U;
            else if (ch == CH_L)
                ev.kind = KIND_CTRL_L;
            else if (ch == CH_C)
                ev.kind = KIND_CTRL_C;
            else
                return;
        end
        else
        begin
            ch = keymap_char(code, held_mods[M_SHIFT]);
            if (ch == CH_ENTER)
                ev.kind = KIND_ENTER;
            else if (ch == CH_BACKSPACE)
                ev.kind = KIND_BACKSPACE;
            else if (ch >= CH_FIRST && ch <= CH_LAST)
                ev.ch = ch;
            else
                return;
        end
        pending_events.push_back(ev);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        err_count++;
    endtask

    task automatic send_key(input logic [RAW_W-1:0] raw);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            raw_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        raw_ch.valid     <= 1'b1;
        raw_ch.raw_event <= raw;
        do
            @(posedge clk);
        while (!raw_ch.ready);
        keys_sent++;
        predict_event(raw);
    endtask

    task automatic wait_drained();
        raw_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_events.size() != 0);
    endtask

    task automatic test_ignored_codes();
        send_key(8'h00);
        send_key(8'h80);
        send_key({1'b1, CODE_LIMIT});
        send_key(8'hFF);
    endtask

    task automatic test_plain_keys();
        send_key({2'b10, 6'd1});
        send_key({2'b10, 6'd30});
        send_key({2'b10, 6'd53});
        send_key({2'b10, 6'd56});
        send_key({2'b10, 6'd15});
        send_key({2'b10, 6'd28});
        send_key({2'b10, 6'd14});
        send_key({2'b00, 6'd30});
    endtask

    task automatic test_shift_layer();
        send_key({2'b10, KEY_SHIFT});
        send_key({2'b10, 6'd1});
        send_key({2'b10, 6'd43});
        send_key({2'b00, KEY_SHIFT});
    endtask

    task automatic test_ctrl_and_fn();
        send_key({2'b10, KEY_CTRL});
        send_key({2'b10, 6'd22});
        send_key({2'b10, 6'd38});
        send_key({2'b10, 6'd45});
        send_key({2'b10, 6'd30});
        // Fn wins over a held Ctrl
        send_key({2'b10, KEY_FN});
        send_key({2'b10, KEY_UP});
        send_key({2'b10, KEY_DOWN});
        send_key({2'b10, KEY_B});
        send_key({2'b10, KEY_W});
        send_key({2'b10, KEY_M});
        send_key({2'b10, KEY_S});
        send_key({2'b10, 6'd30});
        send_key({2'b00, KEY_FN});
        send_key({2'b00, KEY_CTRL});
    endtask

    task automatic test_alt_opt();
        send_key({2'b10, KEY_ALT});
        send_key({2'b10, KEY_OPT});
        send_key({2'b10, 6'd30});
        send_key({2'b00, KEY_ALT});
        send_key({2'b00, KEY_OPT});
    endtask

    task automatic test_output_stall();
        int i;
        wait_drained();
        tx_quiet    = 1'b1;
        rx_hold_len = 150;
        for (i = 0; i < 24; i++)
            send_key({2'b10, 6'($urandom_range(30, 38))});
        tx_quiet = 1'b0;
    endtask

    task automatic test_sender_pause();
        send_key({2'b10, 6'd16});
        send_key({2'b10, 6'd28});
        wait_drained();
        send_key({2'b10, 6'd17});
    endtask

    task automatic test_random_typing();
        int                r;
        int                goal;
        logic [CODE_W-1:0] code;
        goal = keys_handled + RANDOM_KEYS;
        while (keys_handled < goal)
        begin
            // every third stretch of a hundred keys runs without gaps on either side
            tx_quiet = (((goal - keys_handled) / 100) % 3) == 1;
            rx_quiet = tx_quiet;
            r = $urandom_range(0, 99);
            if (r < 8)
                send_key(8'($urandom_range(0, 255)));
            else if (r < 30)
            begin
                case ($urandom_range(0, 4))
                    0:       code = KEY_CTRL;
                    1:       code = KEY_FN;
                    2:       code = KEY_SHIFT;
                    3:       code = KEY_ALT;
                    default: code = KEY_OPT;
                endcase
                send_key({($urandom_range(0, 2) == 0), 1'b0, code});
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    case ($urandom_range(0, 10))
                        0:       code = KEY_UP;
                        1:       code = KEY_DOWN;
                        2:       code = KEY_B;
                        3:       code = KEY_W;
                        4:       code = KEY_M;
                        5:       code = KEY_S;
                        6:       code = 6'd22;
                        7:       code = 6'd38;
                        8:       code = 6'd45;
                        9:       code = 6'd14;
                        default: code = 6'd28;
                    endcase
                end
                else
                    code = 6'($urandom_range(1, 56));
                send_key({(r >= 38), 1'b0, code});
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // result side: random stall per transfer, or a long hold when requested
    initial
    begin
        int n;
        event_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            n = rx_quiet ? 0 : $urandom_range(0, 4);
            if (rx_hold_len > 0)
            begin
                n           = rx_hold_len;
                rx_hold_len = 0;
            end
            if (n > 0)
            begin
                event_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            event_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!event_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            if (pending_events.size() == 0)
                report_mismatch($sformatf("unexpected event kind %0d char 0x%02h",
                                          event_ch.event_kind, event_ch.char_code));
            else
            begin
                front = pending_events.pop_front();
                events_checked++;
                if (event_ch.event_kind !== front.kind)
                    report_mismatch($sformatf("event_kind %0d, expected %s",
                                              event_ch.event_kind, front.kind.name()));
                if (event_ch.char_code !== front.ch)
                    report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                              event_ch.char_code, front.ch));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((raw_ch.valid && raw_ch.ready) || (event_ch.valid && event_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        raw_ch.valid     = 1'b0;
        raw_ch.raw_event = '0;
        held_mods        = '0;
        err_count        = 0;
        keys_sent        = 0;
        keys_handled     = 0;
        events_checked   = 0;
        idle_cycles      = 0;
        rx_hold_len      = 0;
        rx_quiet         = 1'b0;
        tx_quiet         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_codes();
        test_plain_keys();
        test_shift_layer();
        test_ctrl_and_fn();
        test_alt_opt();
        test_output_stall();
        test_sender_pause();
        test_random_typing();

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Sent %0d raw key events, %0d inside the key range; %0d events checked.",
                 keys_sent, keys_handled, events_checked);
        $display("Covered ignored codes, all layers and chords, a long output stall, a pause.");
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: keypad_event_translator.f
hw/rtl/kpt_pkg.sv
hw/rtl/kpt_raw_if.sv
hw/rtl/kpt_event_if.sv
hw/rtl/kpt_front.sv
hw/rtl/kpt_queue.sv
hw/rtl/kpt_back.sv
hw/rtl/keypad_event_translator.sv
tb/keypad_event_translator_tb.sv
